### rtl/core/ncc_pkg.sv
// Package for the nearest-centroid classifier: sizes, payload structs and
// the command and status structs between the controller and the datapath.
// Depends on nothing; every other file of the block but ncc_ram imports it.
package ncc_pkg;

  // Block size.
  localparam int NUM_CLASSES = 16;
  localparam int VECTOR_DIM  = 64;

  // Index and address widths.
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int ELEM_W = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
  localparam int ADDR_W = $clog2(NUM_CLASSES * VECTOR_DIM);

  // Field widths.
  localparam int FEAT_W  = 16;
  localparam int LABEL_W = 4;
  localparam int COUNT_W = 16;
  localparam int DIST_W  = 38;

  // Arithmetic widths.
  localparam int SUM_W  = 33;
  localparam int CENT_W = 25;
  localparam int FRAC_W = 8;
  localparam int DIVD_W = SUM_W + FRAC_W;
  localparam int DIFF_W = CENT_W + 1;
  localparam int MAG_W  = CENT_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int ACC_W  = PROD_W + $clog2(VECTOR_DIM);
  localparam int DIST_SHIFT = 2 * FRAC_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [63:0]        DIST_MAX  = 64'((64'd1 << DIST_W) - 64'd1);

  // Kind codes.
  localparam logic KIND_UPDATE   = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  // One input word.
  typedef struct packed {
    logic                      kind;
    logic [LABEL_W-1:0]        class_label;
    logic signed [FEAT_W-1:0]  feature_value;
    logic                      last_element;
  } in_t;

  // One result word.
  typedef struct packed {
    logic               done_kind;
    logic [LABEL_W-1:0] predicted_label;
    logic               no_class;
    logic [DIST_W-1:0]  min_distance_sq;
    logic [COUNT_W-1:0] member_count;
  } out_t;

  // Commands from the controller.
  typedef struct packed {
    logic              take;
    logic              rd;
    logic              c_dif;
    logic              c_mul;
    logic              c_clr;
    logic              c_acc;
    logic              c_init;
    logic              c_cmp;
    logic              u_add;
    logic              div_start;
    logic              u_wr;
    logic              emit;
    logic [CLS_W-1:0]  cls;
    logic [ELEM_W-1:0] elem;
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic               kind;
    logic [LABEL_W-1:0] lab;
    logic               cls_valid;
    logic               upd_ok;
    logic               div_done;
  } st_t;

endpackage

### rtl/core/ncc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ncc_ram #(
  parameter int W = 16,
  parameter int D = 64,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/core/ncc_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ncc_pkg for the operand widths.
module ncc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ncc_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [ncc_pkg::COUNT_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [ncc_pkg::DIVD_W-1:0]  quotient_o
);
  import ncc_pkg::*;

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic                run_q, done_q;
  logic [STEP_W-1:0]   step_q;
  logic [COUNT_W-1:0]  rem_q, dvs_q;
  logic [DIVD_W-1:0]   quo_q;
  logic [COUNT_W:0]    trial, sub;
  logic                ge;

  // One trial subtraction per step.
  always_comb begin
    trial = {rem_q, quo_q[DIVD_W-1]};
    sub   = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= run_q && (step_q == STEP_W'(1));
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= STEP_W'(DIVD_W);
      end else if (run_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/core/ncc_ctrl.sv
// Controller of the classifier: collects words, then sequences the update
// or classify pass over classes and elements. Depends on ncc_pkg.
module ncc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           last_i,
  input  ncc_pkg::st_t   st_i,
  output ncc_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import ncc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] U_CHK  = 4'd2;
  localparam logic [3:0] U_RD   = 4'd3;
  localparam logic [3:0] U_ADD  = 4'd4;
  localparam logic [3:0] U_DST  = 4'd5;
  localparam logic [3:0] U_DIV  = 4'd6;
  localparam logic [3:0] U_WR   = 4'd7;
  localparam logic [3:0] C_CLS  = 4'd8;
  localparam logic [3:0] C_RD   = 4'd9;
  localparam logic [3:0] C_DIF  = 4'd10;
  localparam logic [3:0] C_MUL  = 4'd11;
  localparam logic [3:0] C_ACC  = 4'd12;
  localparam logic [3:0] C_CMP  = 4'd13;
  localparam logic [3:0] C_NXT  = 4'd14;
  localparam logic [3:0] S_EMIT = 4'd15;

  logic [3:0]        state_q, state_d;
  logic [CLS_W-1:0]  cls_q, cls_d;
  logic [ELEM_W-1:0] elem_q, elem_d;
  logic              elem_last, cls_last;

  assign elem_last = elem_q == ELEM_W'(VECTOR_DIM - 1);
  assign cls_last  = cls_q == CLS_W'(NUM_CLASSES - 1);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cls_d   = cls_q;
    elem_d  = elem_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = start_i;
        if (start_i && last_i) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (st_i.kind == KIND_CLASSIFY) begin
          cls_d        = '0;
          cmd_o.c_init = 1'b1;
          state_d      = C_CLS;
        end else begin
          cls_d   = CLS_W'(st_i.lab);
          state_d = U_CHK;
        end
      end
      U_CHK: begin
        elem_d  = '0;
        state_d = st_i.upd_ok ? U_RD : S_EMIT;
      end
      U_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = U_ADD;
      end
      U_ADD: begin
        cmd_o.u_add = 1'b1;
        state_d     = U_DST;
      end
      U_DST: begin
        cmd_o.div_start = 1'b1;
        state_d         = U_DIV;
      end
      U_DIV: begin
        if (st_i.div_done) begin
          state_d = U_WR;
        end
      end
      U_WR: begin
        cmd_o.u_wr = 1'b1;
        if (elem_last) begin
          state_d = S_EMIT;
        end else begin
          elem_d  = elem_q + ELEM_W'(1);
          state_d = U_RD;
        end
      end
      C_CLS: begin
        elem_d = '0;
        if (st_i.cls_valid) begin
          cmd_o.c_clr = 1'b1;
          state_d     = C_RD;
        end else begin
          state_d = C_NXT;
        end
      end
      C_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = C_DIF;
      end
      C_DIF: begin
        cmd_o.c_dif = 1'b1;
        state_d     = C_MUL;
      end
      C_MUL: begin
        cmd_o.c_mul = 1'b1;
        state_d     = C_ACC;
      end
      C_ACC: begin
        cmd_o.c_acc = 1'b1;
        if (elem_last) begin
          state_d = C_CMP;
        end else begin
          elem_d  = elem_q + ELEM_W'(1);
          state_d = C_RD;
        end
      end
      C_CMP: begin
        cmd_o.c_cmp = 1'b1;
        state_d     = C_NXT;
      end
      C_NXT: begin
        if (cls_last) begin
          state_d = S_EMIT;
        end else begin
          cls_d   = cls_q + CLS_W'(1);
          state_d = C_CLS;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.cls  = cls_q;
    cmd_o.elem = elem_q;
  end

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cls_q   <= '0;
      elem_q  <= '0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      elem_q  <= elem_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

### rtl/core/ncc_dp.sv
// Datapath of the classifier: vector buffer, class sums and centroids,
// divider, distance unit, class table and result register.
// Depends on ncc_pkg, ncc_ram and ncc_div.
module ncc_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ncc_pkg::cmd_t  cmd_i,
  input  ncc_pkg::in_t   item_i,
  output ncc_pkg::st_t   st_o,
  output ncc_pkg::out_t  result_o,
  output logic           result_valid_o
);
  import ncc_pkg::*;

  // Open vector state.
  logic [ELEM_W:0]      cnt_q;
  logic                 first_q, kind_q;
  logic [LABEL_W-1:0]   lab_q;
  logic                 buf_we;
  logic [FEAT_W-1:0]    buf_rd;
  logic                 in_rng_q;
  logic signed [FEAT_W-1:0] x;

  assign buf_we = cmd_i.take && (cnt_q < (ELEM_W + 1)'(VECTOR_DIM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= 1'b1;
      kind_q  <= KIND_UPDATE;
      lab_q   <= '0;
    end else begin
      if (cmd_i.take) begin
        if (first_q) begin
          kind_q <= item_i.kind;
          lab_q  <= item_i.class_label;
        end
        first_q <= item_i.last_element;
        if (buf_we) begin
          cnt_q <= cnt_q + (ELEM_W + 1)'(1);
        end
      end else if (cmd_i.emit) begin
        cnt_q <= '0;
      end
    end
  end

  ncc_ram #(.W(FEAT_W), .D(VECTOR_DIM)) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (cnt_q[ELEM_W-1:0]),
    .wdata_i (item_i.feature_value),
    .raddr_i (cmd_i.elem),
    .rdata_o (buf_rd)
  );

  // Elements past the end of a short vector read as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      in_rng_q <= {1'b0, cmd_i.elem} < cnt_q;
    end
  end
  assign x = in_rng_q ? signed'(buf_rd) : '0;

  // Class table.
  logic                valid_q [NUM_CLASSES];
  logic [COUNT_W-1:0]  mem_q   [NUM_CLASSES];
  logic                cls_valid, lab_in, upd_ok;
  logic [COUNT_W-1:0]  cls_mem, n_new;

  assign cls_valid = valid_q[cmd_i.cls];
  assign cls_mem   = mem_q[cmd_i.cls];
  assign lab_in    = 32'(lab_q) < NUM_CLASSES;
  assign upd_ok    = lab_in && !(cls_valid && (cls_mem == COUNT_MAX));
  assign n_new     = cls_valid ? cls_mem + COUNT_W'(1) : COUNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        valid_q[i] <= 1'b0;
        mem_q[i]   <= '0;
      end
    end else if (cmd_i.emit && (kind_q == KIND_UPDATE) && upd_ok) begin
      valid_q[cmd_i.cls] <= 1'b1;
      mem_q[cmd_i.cls]   <= n_new;
    end
  end

  // Sum and centroid stores, addressed by class and element.
  logic [ADDR_W-1:0]  addr;
  logic [SUM_W-1:0]   sum_rd;
  logic [CENT_W-1:0]  cent_rd, cent_new;
  logic signed [SUM_W-1:0] new_sum, sum_q;

  assign addr = ADDR_W'(cmd_i.cls) * ADDR_W'(VECTOR_DIM) + ADDR_W'(cmd_i.elem);
  assign new_sum = cls_valid ? signed'(sum_rd) + SUM_W'(x) : SUM_W'(x);

  ncc_ram #(.W(SUM_W), .D(NUM_CLASSES * VECTOR_DIM)) u_sum (
    .clk_i   (clk_i),
    .we_i    (cmd_i.u_add),
    .waddr_i (addr),
    .wdata_i (new_sum),
    .raddr_i (addr),
    .rdata_o (sum_rd)
  );

  ncc_ram #(.W(CENT_W), .D(NUM_CLASSES * VECTOR_DIM)) u_cent (
    .clk_i   (clk_i),
    .we_i    (cmd_i.u_wr),
    .waddr_i (addr),
    .wdata_i (cent_new),
    .raddr_i (addr),
    .rdata_o (cent_rd)
  );

  // Centroid = sum * 256 / count, truncated toward zero.
  logic               neg_q, div_done;
  logic [SUM_W-1:0]   sum_mag;
  logic [DIVD_W-1:0]  quo;

  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.u_add) begin
      sum_q <= new_sum;
    end
    if (cmd_i.div_start) begin
      neg_q <= sum_q[SUM_W-1];
    end
  end

  ncc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({sum_mag, FRAC_W'(0)}),
    .divisor_i  (n_new),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign cent_new = neg_q ? CENT_W'(-quo) : CENT_W'(quo);

  // Distance: difference, square, accumulate, compare.
  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]   mag_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]   acc_q, best_q;
  logic               found_q;
  logic [CLS_W-1:0]   best_cls_q;
  logic [COUNT_W-1:0] best_cnt_q;

  assign diff = (DIFF_W'(x) <<< FRAC_W) - DIFF_W'(signed'(cent_rd));

  always_ff @(posedge clk_i) begin
    if (cmd_i.c_dif) begin
      mag_q <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end
    if (cmd_i.c_mul) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(mag_q);
    end
    if (cmd_i.c_clr) begin
      acc_q <= '0;
    end else if (cmd_i.c_acc) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.c_cmp && (!found_q || (acc_q < best_q))) begin
      best_q     <= acc_q;
      best_cls_q <= cmd_i.cls;
      best_cnt_q <= cls_mem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.c_init) begin
      found_q <= 1'b0;
    end else if (cmd_i.c_cmp) begin
      found_q <= 1'b1;
    end
  end

  // Result formation.
  out_t        res_d, res_q;
  logic        res_valid_q;
  logic [63:0] dist_x;

  always_comb begin
    dist_x = 64'(best_q >> DIST_SHIFT);
    res_d  = '0;
    res_d.done_kind = kind_q;
    if (kind_q == KIND_UPDATE) begin
      res_d.predicted_label = lab_q;
      if (upd_ok) begin
        res_d.member_count = n_new;
      end else if (lab_in) begin
        res_d.member_count = cls_mem;
      end
    end else if (!found_q) begin
      res_d.no_class = 1'b1;
    end else begin
      res_d.predicted_label = LABEL_W'(best_cls_q);
      res_d.min_distance_sq = (dist_x > DIST_MAX) ? '1 : dist_x[DIST_W-1:0];
      res_d.member_count    = best_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

  // Status.
  always_comb begin
    st_o.kind      = kind_q;
    st_o.lab       = lab_q;
    st_o.cls_valid = cls_valid;
    st_o.upd_ok    = upd_ok;
    st_o.div_done  = div_done;
  end

endmodule

### rtl/core/nearest_centroid_classifier_unit.sv
// Top level of the nearest-centroid classifier.
// Depends on ncc_pkg, ncc_ctrl and ncc_dp.
//
// Usage:
// Input: one vector element per word on item_i, taken at a clock edge where
// start is high and busy is low. kind and class_label count on the first
// word of a vector; last_element closes it. Elements past VECTOR_DIM are
// dropped, missing ones count as zero.
// While busy is low a word is taken every cycle that start is high. After
// the closing word, busy stays high while the vector is processed:
//   update:   per element, four control steps around a run of the
//             bit-serial divider (41 quotient bits); an update to a full
//             class skips the elements and goes straight to the result.
//   classify: each class is checked; for each known class every element
//             is read, differenced, squared and accumulated, then compared.
// Output: result_o is valid for exactly one cycle with result_valid_o high,
// the first cycle in which busy is low again. The receiver cannot stall it.
// Reset clears the class table and the open vector; sum and centroid
// memories need no clearing since a class is written before it is read.
module nearest_centroid_classifier_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ncc_pkg::in_t  item_i,
  output ncc_pkg::out_t result_o,
  output logic          result_valid_o
);
  import ncc_pkg::*;

  cmd_t cmd;
  st_t  st;

  ncc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .last_i (item_i.last_element),
    .st_i   (st),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  ncc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .st_o           (st),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
